/* rtl/core/ofr_pkg.sv */
// ----------------------------------------------------------------------------
// ofr_pkg
// Types and constants shared by the orthonormal frame pipeline.
// ----------------------------------------------------------------------------
package ofr_pkg;

    localparam int CompW = 32;
    localparam int FracBits = 30;
    localparam int NormMagW = 33;    // widest magnitude handed to the normalizer
    localparam int SqrtBits = 32;    // root bits of a sum below 2^64
    localparam int DivBits = 32;     // quotient bits, the quotient is at most 2^30

    typedef struct packed {
        logic signed [CompW-1:0] from_x;
        logic signed [CompW-1:0] from_y;
        logic signed [CompW-1:0] from_z;
        logic signed [CompW-1:0] to_x;
        logic signed [CompW-1:0] to_y;
        logic signed [CompW-1:0] to_z;
    } in_item_t;

    typedef struct packed {
        logic signed [CompW-1:0] axis1_x;
        logic signed [CompW-1:0] axis1_y;
        logic signed [CompW-1:0] axis1_z;
        logic signed [CompW-1:0] axis2_x;
        logic signed [CompW-1:0] axis2_y;
        logic signed [CompW-1:0] axis2_z;
        logic signed [CompW-1:0] axis3_x;
        logic signed [CompW-1:0] axis3_y;
        logic signed [CompW-1:0] axis3_z;
        logic                    degenerate;
    } out_item_t;

    // One vector handed to a normalizer, as signs and magnitudes.
    typedef struct packed {
        logic [2:0]                 neg;
        logic [2:0][NormMagW-1:0]   mag;
    } nvec_t;

    // A normalized vector in Q2.30 and whether it was nonzero.
    typedef struct packed {
        logic                           ok;
        logic [2:0][CompW-1:0]          comp;
    } uvec_t;

endpackage

/* rtl/core/ofr_norm.sv */
// ----------------------------------------------------------------------------
// ofr_norm
// Pipelined vector normalizer: scale, square sum, bit-serial square root
// unrolled one bit per stage, then restoring division one bit per stage.
// ----------------------------------------------------------------------------
module ofr_norm #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ofr_pkg::nvec_t      in_vec,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output ofr_pkg::uvec_t      out_vec,
    output logic [SIDE_W-1:0]   out_side
);
    import ofr_pkg::*;

    localparam int ShW = 6;
    localparam int SqStages = SqrtBits;
    localparam int DvStages = DivBits;
    localparam int NumW = 31 + FracBits + 1;   // m << 30 plus rounding, below 2^62

    // ---- stage A: leading bit of the largest magnitude ----
    logic                  a_v_reg;
    logic [SIDE_W-1:0]     a_side_reg;
    logic [2:0]            a_neg_reg;
    logic [2:0][NormMagW-1:0] a_mag_reg;
    logic [ShW-1:0]        a_lead_reg;
    logic                  a_zero_reg;

    logic [NormMagW-1:0] or_all;
    logic [ShW-1:0]      lead_c;
    always_comb
    begin
        or_all = in_vec.mag[0] | in_vec.mag[1] | in_vec.mag[2];
        lead_c = '0;
        for (int i = 0; i < NormMagW; i++)
        begin
            if (or_all[i])
            begin
                lead_c = ShW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= in_side;
        a_neg_reg  <= in_vec.neg;
        a_mag_reg  <= in_vec.mag;
        a_lead_reg <= lead_c;
        a_zero_reg <= (or_all == '0);
    end

    // ---- stage B: shift so the largest lies in [2^30, 2^31) ----
    logic                  b_v_reg;
    logic [SIDE_W-1:0]     b_side_reg;
    logic [2:0]            b_neg_reg;
    logic [2:0][30:0]      b_m_reg;
    logic                  b_zero_reg;

    logic [2:0][30:0] sh_c;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (a_lead_reg >= ShW'(30))
            begin
                sh_c[i] = 31'(a_mag_reg[i] >> (a_lead_reg - ShW'(30)));
            end
            else
            begin
                sh_c[i] = 31'(a_mag_reg[i] << (ShW'(30) - a_lead_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_side_reg <= a_side_reg;
        b_neg_reg  <= a_neg_reg;
        b_m_reg    <= sh_c;
        b_zero_reg <= a_zero_reg;
    end

    // ---- stage C: squares ----
    logic                  c_v_reg;
    logic [SIDE_W-1:0]     c_side_reg;
    logic [2:0]            c_neg_reg;
    logic [2:0][30:0]      c_m_reg;
    logic [2:0][61:0]      c_sq_reg;
    logic                  c_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else
        begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_side_reg <= b_side_reg;
        c_neg_reg  <= b_neg_reg;
        c_m_reg    <= b_m_reg;
        c_zero_reg <= b_zero_reg;
        for (int i = 0; i < 3; i++)
        begin
            c_sq_reg[i] <= 62'(b_m_reg[i]) * 62'(b_m_reg[i]);
        end
    end

    // ---- square root, one result bit per stage ----
    logic [SqStages:0]                 q_v_reg;
    logic [SqStages:0][SIDE_W-1:0]     q_side_reg;
    logic [SqStages:0][2:0]            q_neg_reg;
    logic [SqStages:0][2:0][30:0]      q_m_reg;
    logic [SqStages:0]                 q_zero_reg;
    logic [SqStages:0][63:0]           q_rem_reg;
    logic [SqStages:0][SqrtBits-1:0]   q_root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_v_reg[0] <= 1'b0;
        end
        else
        begin
            q_v_reg[0] <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_side_reg[0] <= c_side_reg;
        q_neg_reg[0]  <= c_neg_reg;
        q_m_reg[0]    <= c_m_reg;
        q_zero_reg[0] <= c_zero_reg;
        q_rem_reg[0]  <= 64'(c_sq_reg[0]) + 64'(c_sq_reg[1]) + 64'(c_sq_reg[2]);
        q_root_reg[0] <= '0;
    end

    for (genvar k = 0; k < SqStages; k++)
    begin : g_sqrt
        localparam int Bit = SqStages - 1 - k;
        logic [65:0] trial;
        logic [65:0] remw;
        logic        take;
        always_comb
        begin
            trial = (66'(q_root_reg[k]) << (Bit + 1)) | (66'(1) << (2 * Bit));
            remw  = 66'(q_rem_reg[k]);
            take  = (remw >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                q_v_reg[k+1] <= q_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            q_side_reg[k+1] <= q_side_reg[k];
            q_neg_reg[k+1]  <= q_neg_reg[k];
            q_m_reg[k+1]    <= q_m_reg[k];
            q_zero_reg[k+1] <= q_zero_reg[k];
            q_rem_reg[k+1]  <= take ? 64'(remw - trial) : q_rem_reg[k];
            q_root_reg[k+1] <= q_root_reg[k] | (take ? (SqrtBits'(1) << Bit) : '0);
        end
    end

    // ---- divisions, three lanes, one quotient bit per stage ----
    logic [DvStages:0]                 d_v_reg;
    logic [DvStages:0][SIDE_W-1:0]     d_side_reg;
    logic [DvStages:0][2:0]            d_neg_reg;
    logic [DvStages:0]                 d_zero_reg;
    logic [DvStages:0][SqrtBits-1:0]   d_len_reg;
    logic [DvStages:0][2:0][NumW-1:0]  d_rem_reg;
    logic [DvStages:0][2:0][DivBits-1:0] d_quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg[0] <= 1'b0;
        end
        else
        begin
            d_v_reg[0] <= q_v_reg[SqStages];
        end
    end

    always_ff @(posedge clk)
    begin
        d_side_reg[0] <= q_side_reg[SqStages];
        d_neg_reg[0]  <= q_neg_reg[SqStages];
        d_zero_reg[0] <= q_zero_reg[SqStages] || (q_root_reg[SqStages] == '0);
        d_len_reg[0]  <= q_root_reg[SqStages];
        for (int i = 0; i < 3; i++)
        begin
            d_rem_reg[0][i] <= (NumW'(q_m_reg[SqStages][i]) << FracBits)
                               + NumW'(q_root_reg[SqStages] >> 1);
            d_quo_reg[0][i] <= '0;
        end
    end

    for (genvar k = 0; k < DvStages; k++)
    begin : g_div
        localparam int Bit = DvStages - 1 - k;
        logic [2:0][NumW+DivBits-1:0] trial;
        logic [2:0] take;
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = (NumW+DivBits)'(d_len_reg[k]) << Bit;
                take[i]  = ((NumW+DivBits)'(d_rem_reg[k][i]) >= trial[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_v_reg[k+1] <= 1'b0;
            end
            else
            begin
                d_v_reg[k+1] <= d_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            d_side_reg[k+1] <= d_side_reg[k];
            d_neg_reg[k+1]  <= d_neg_reg[k];
            d_zero_reg[k+1] <= d_zero_reg[k];
            d_len_reg[k+1]  <= d_len_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                d_rem_reg[k+1][i] <= take[i]
                    ? NumW'((NumW+DivBits)'(d_rem_reg[k][i]) - trial[i])
                    : d_rem_reg[k][i];
                d_quo_reg[k+1][i] <= d_quo_reg[k][i]
                    | (take[i] ? (DivBits'(1) << Bit) : '0);
            end
        end
    end

    always_comb
    begin
        out_valid  = d_v_reg[DvStages];
        out_side   = d_side_reg[DvStages];
        out_vec.ok = !d_zero_reg[DvStages];
        for (int i = 0; i < 3; i++)
        begin
            if (d_zero_reg[DvStages])
            begin
                out_vec.comp[i] = '0;
            end
            else if (d_neg_reg[DvStages][i])
            begin
                out_vec.comp[i] = CompW'(-d_quo_reg[DvStages][i]);
            end
            else
            begin
                out_vec.comp[i] = CompW'(d_quo_reg[DvStages][i]);
            end
        end
    end

    // A normalized component never exceeds one in Q2.30.
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_vec.ok |->
            d_quo_reg[DvStages][0] <= (DivBits'(1) << FracBits) &&
            d_quo_reg[DvStages][1] <= (DivBits'(1) << FracBits) &&
            d_quo_reg[DvStages][2] <= (DivBits'(1) << FracBits))
        else $error("normalized component above one");

    // After the scale stage the largest magnitude has its top bit at 30.
    a_scale: assert property (@(posedge clk) disable iff (!rst_n)
        b_v_reg && !b_zero_reg |-> ((b_m_reg[0] | b_m_reg[1] | b_m_reg[2]) >> 30) == 31'd1)
        else $error("scale stage out of range");

    // A zero input vector comes out flagged as not normalized.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        c_v_reg && c_zero_reg |-> ##(SqStages + DvStages + 2) !out_vec.ok)
        else $error("zero vector lost its flag");

endmodule

/* rtl/core/orthonormal_frame_from_two_points.sv */
// ----------------------------------------------------------------------------
// orthonormal_frame_from_two_points
// Right-handed orthonormal frame in Q2.30 from two Q16.16 points.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// command   in         start, busy        cmd   (ofr_pkg::in_item_t)
// result    out        done strobe        res   (ofr_pkg::out_item_t)
//
// A frame is accepted in every cycle: busy is held low, since the pipeline
// never stalls and the receiver cannot hold results off. Each frame passes
// three normalizers in a row; each normalizer is 4 scale/square/sum stages,
// 32 square root stages and 33 division stages, 69 in all. With the
// difference stage, the product and rounding stages and the output register
// there are 1 + 3 * 69 + 3 = 211 register stages between a command transfer
// and done, the first loaded at the accepting edge. Reset clears only the
// valid bits; payload registers carry no reset.
//
module orthonormal_frame_from_two_points (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ofr_pkg::in_item_t     cmd,
    output logic                  done,
    output ofr_pkg::out_item_t    res
);
    import ofr_pkg::*;

    localparam int SideA = 1;
    localparam int SideB = 1 + 3 * CompW;
    localparam int SideC = 1 + 6 * CompW;

    assign busy = 1'b0;

    // Stage 0: exact 33-bit differences, as signs and magnitudes.
    logic  s0_v_reg;
    nvec_t s0_vec_reg;
    logic  go;
    assign go = start && !busy;

    nvec_t diff_c;
    always_comb
    begin
        logic signed [CompW:0] d [3];
        d[0] = {cmd.from_x[CompW-1], cmd.from_x} - {cmd.to_x[CompW-1], cmd.to_x};
        d[1] = {cmd.from_y[CompW-1], cmd.from_y} - {cmd.to_y[CompW-1], cmd.to_y};
        d[2] = {cmd.from_z[CompW-1], cmd.from_z} - {cmd.to_z[CompW-1], cmd.to_z};
        for (int i = 0; i < 3; i++)
        begin
            diff_c.neg[i] = d[i][CompW];
            diff_c.mag[i] = d[i][CompW] ? NormMagW'(-d[i]) : NormMagW'(d[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_vec_reg <= diff_c;
    end

    // First normalizer gives axis 1.
    logic  n1_v;
    uvec_t n1_vec;
    logic [SideA-1:0] n1_side;

    ofr_norm #(.SIDE_W(SideA)) u_norm1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_v_reg),
        .in_vec    (s0_vec_reg),
        .in_side   (1'b0),
        .out_valid (n1_v),
        .out_vec   (n1_vec),
        .out_side  (n1_side)
    );

    // Helper axis choice and the exact cross product with it.
    logic [2:0][CompW-1:0] a1;
    logic [2:0][CompW-1:0] ab;
    nvec_t cr_c;
    always_comb
    begin
        a1 = n1_vec.comp;
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = a1[i][CompW-1] ? CompW'(-a1[i]) : a1[i];
        end
        cr_c = '0;
        if (ab[0] <= ab[1] && ab[0] <= ab[2])
        begin
            cr_c.mag[1] = NormMagW'(ab[2]);  cr_c.neg[1] = a1[2][CompW-1];
            cr_c.mag[2] = NormMagW'(ab[1]);  cr_c.neg[2] = !a1[1][CompW-1];
        end
        else if (ab[1] <= ab[0] && ab[1] <= ab[2])
        begin
            cr_c.mag[0] = NormMagW'(ab[2]);  cr_c.neg[0] = !a1[2][CompW-1];
            cr_c.mag[2] = NormMagW'(ab[0]);  cr_c.neg[2] = a1[0][CompW-1];
        end
        else
        begin
            cr_c.mag[0] = NormMagW'(ab[1]);  cr_c.neg[0] = a1[1][CompW-1];
            cr_c.mag[1] = NormMagW'(ab[0]);  cr_c.neg[1] = !a1[0][CompW-1];
        end
    end

    // Degenerate items ride through with a flag; their vector is zero anyway.
    logic [SideB-1:0] n2_in_side;
    assign n2_in_side = {!n1_vec.ok, a1};

    logic  n2_v;
    uvec_t n2_vec;
    logic [SideB-1:0] n2_side;

    ofr_norm #(.SIDE_W(SideB)) u_norm2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n1_v),
        .in_vec    (cr_c),
        .in_side   (n2_in_side),
        .out_valid (n2_v),
        .out_vec   (n2_vec),
        .out_side  (n2_side)
    );

    // Axis 1 cross axis 2: products in one stage, difference and rounding next.
    logic [2:0][CompW-1:0] a1d;
    assign a1d = n2_side[3*CompW-1:0];

    logic                  p_v_reg;
    logic [SideB-1:0]      p_side_reg;
    logic [2:0][CompW-1:0] p_e2_reg;
    logic signed [5:0][63:0] p_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
        end
        else
        begin
            p_v_reg <= n2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        p_side_reg <= n2_side;
        p_e2_reg   <= n2_vec.comp;
        p_prod_reg[0] <= $signed(a1d[1]) * $signed(n2_vec.comp[2]);
        p_prod_reg[1] <= $signed(a1d[2]) * $signed(n2_vec.comp[1]);
        p_prod_reg[2] <= $signed(a1d[2]) * $signed(n2_vec.comp[0]);
        p_prod_reg[3] <= $signed(a1d[0]) * $signed(n2_vec.comp[2]);
        p_prod_reg[4] <= $signed(a1d[0]) * $signed(n2_vec.comp[1]);
        p_prod_reg[5] <= $signed(a1d[1]) * $signed(n2_vec.comp[0]);
    end

    nvec_t r_c;
    always_comb
    begin
        logic signed [63:0] v;
        logic [63:0]        m;
        for (int i = 0; i < 3; i++)
        begin
            v = $signed(p_prod_reg[2*i]) - $signed(p_prod_reg[2*i+1]);
            m = v[63] ? 64'(-v) : 64'(v);
            r_c.neg[i] = v[63];
            r_c.mag[i] = NormMagW'((m + (64'(1) << (FracBits - 1))) >> FracBits);
        end
    end

    logic  r_v_reg;
    nvec_t r_vec_reg;
    logic [SideC-1:0] r_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg <= 1'b0;
        end
        else
        begin
            r_v_reg <= p_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_vec_reg  <= r_c;
        r_side_reg <= {p_side_reg, p_e2_reg};
    end

    logic  n3_v;
    uvec_t n3_vec;
    logic [SideC-1:0] n3_side;

    ofr_norm #(.SIDE_W(SideC)) u_norm3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_v_reg),
        .in_vec    (r_vec_reg),
        .in_side   (r_side_reg),
        .out_valid (n3_v),
        .out_vec   (n3_vec),
        .out_side  (n3_side)
    );

    // Output register; the side band holds degenerate, axis 1 and axis 2.
    logic                  o_v_reg;
    out_item_t             o_res_reg;
    logic [2:0][CompW-1:0] f_a1;
    logic [2:0][CompW-1:0] f_a2;
    logic                  f_deg;

    assign f_deg = n3_side[SideC-1];
    assign f_a1  = n3_side[6*CompW-1:3*CompW];
    assign f_a2  = n3_side[3*CompW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg <= n3_v;
        end
    end

    always_ff @(posedge clk)
    begin
        o_res_reg.axis1_x    <= f_a1[0];
        o_res_reg.axis1_y    <= f_a1[1];
        o_res_reg.axis1_z    <= f_a1[2];
        o_res_reg.axis2_x    <= f_deg ? '0 : f_a2[0];
        o_res_reg.axis2_y    <= f_deg ? '0 : f_a2[1];
        o_res_reg.axis2_z    <= f_deg ? '0 : f_a2[2];
        o_res_reg.axis3_x    <= f_deg ? '0 : n3_vec.comp[0];
        o_res_reg.axis3_y    <= f_deg ? '0 : n3_vec.comp[1];
        o_res_reg.axis3_z    <= f_deg ? '0 : n3_vec.comp[2];
        o_res_reg.degenerate <= f_deg;
    end

    assign done = o_v_reg;
    assign res  = o_res_reg;

    // A degenerate frame has axes 1 and 3 at zero; axis 2 is zeroed at the output register.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && res.degenerate |->
            res.axis1_x == '0 && res.axis1_y == '0 && res.axis1_z == '0 &&
            res.axis3_x == '0 && res.axis3_y == '0 && res.axis3_z == '0)
        else $error("degenerate frame with nonzero axis");

    // A nondegenerate frame has a second axis with a zero helper component.
    a_helper: assert property (@(posedge clk) disable iff (!rst_n)
        done && !res.degenerate |->
            res.axis2_x == '0 || res.axis2_y == '0 || res.axis2_z == '0)
        else $error("second axis not perpendicular to a coordinate axis");

    // Items leave at a fixed latency after leaving the first normalizer:
    // two more normalizers, the product and rounding stages and the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        n1_v |-> ##(2 * 69 + 3) done)
        else $error("frame lost in pipeline");

endmodule
